@@ rtl/positional_list_store_core_macros.svh @@
// Assertion macros shared by the positional list store RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is held.
`define PLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled while reset is held.
`define PLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/plc_pkg.sv @@
// Shared types and constants for the positional list store.
// No dependencies; imported by every module of the block.
package plc_pkg;

    localparam int CMD_W        = 2;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 8;
    localparam int DEF_CAPACITY = 64;
    localparam int GRP          = 8;

    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic             exec;
        logic             ins;
        logic             del;
        logic [VAL_W-1:0] val;
    } t_cell_ctl;

endpackage

@@ rtl/positional_list_store_core.sv @@
// Positional list store: a row of CAPACITY byte cells with a length register.
// The start transfer passes through the cell update, the grouped first-match search and
// the result register before the registered result strobe; busy holds off a new command
// until then. Results are strobed for one cycle and cannot be stalled.
// Synchronous reset empties the list; cell contents are not cleared.
// Depends on plc_pkg, plc_cell, plc_find and positional_list_store_core_macros.svh.
module positional_list_store_core #(
    parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [plc_pkg::CMD_W-1:0] i_cmd,
    input  logic [plc_pkg::POS_W-1:0] i_position,
    input  logic [plc_pkg::VAL_W-1:0] i_value,
    output logic                      o_valid,
    output logic                      o_ok,
    output logic [plc_pkg::VAL_W-1:0] o_item,
    output logic [plc_pkg::POS_W-1:0] o_found_at,
    output logic [plc_pkg::POS_W-1:0] o_count,
    output logic                      o_is_empty
);
    import plc_pkg::*;
    `include "positional_list_store_core_macros.svh"

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CMD_W-1:0] r_cmd;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [LW-1:0]    r_fill;
    logic [LW-1:0]    n_fill;
    logic             r_ok;
    logic [VAL_W-1:0] r_item;

    logic [CW-1:0]    w_pos_x;
    logic [CW-1:0]    w_fill_x;
    logic [IW-1:0]    w_p;
    logic             w_in_rng;
    logic             w_ins_ok;
    logic             w_accept;
    t_cell_ctl        w_ctl;

    logic [VAL_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic             w_hit;
    logic [LW-1:0]    w_found;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_pos_x  = CW'(r_pos);
    assign w_fill_x = CW'(r_fill);
    assign w_p      = IW'(w_pos_x - CW'(1));
    assign w_in_rng = (w_pos_x != '0) && (w_pos_x <= w_fill_x);
    assign w_ins_ok = (w_pos_x != '0) && (w_pos_x <= w_fill_x + CW'(1))
                      && (w_fill_x < CW'(CAPACITY));

    always_comb begin
        w_ctl      = '0;
        w_ctl.exec = (r_state == S_EXEC);
        w_ctl.ins  = w_ctl.exec && (r_cmd == CMD_INSERT) && w_ins_ok;
        w_ctl.del  = w_ctl.exec && (r_cmd == CMD_DELETE) && w_in_rng;
        w_ctl.val  = r_val;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        // The first cell never takes from its left and the last keeps its own byte.
        assign w_left  = (i == 0) ? r_val : w_data[(i == 0) ? 0 : i - 1];
        assign w_right = (i == CAPACITY - 1) ? w_data[i]
                                             : w_data[(i == CAPACITY - 1) ? i : i + 1];
        plc_cell #(
            .IDX (i),
            .IW  (IW),
            .LW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_p),
            .i_fill  (r_fill),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[i]),
            .o_match (w_match[i])
        );
    end

    plc_find #(
        .N  (CAPACITY),
        .PW (LW)
    ) u_find (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_pos   (w_found)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) begin
                n_state = S_EXEC;
            end
            S_EXEC:  n_state = S_GRP;
            S_GRP:   n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (w_ctl.ins) begin
            n_fill = r_fill + LW'(1);
        end else if (w_ctl.del) begin
            n_fill = r_fill - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            o_valid <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (r_state == S_EXEC) begin
            r_ok   <= w_ctl.ins || w_ctl.del || ((r_cmd == CMD_GET) && w_in_rng);
            r_item <= (((r_cmd == CMD_GET) || (r_cmd == CMD_DELETE)) && w_in_rng)
                      ? w_data[w_p] : '0;
        end
        if (r_state == S_DONE) begin
            o_ok       <= (r_cmd == CMD_LOCATE) ? w_hit : r_ok;
            o_item     <= r_item;
            o_found_at <= ((r_cmd == CMD_LOCATE) && w_hit) ? POS_W'(w_found) : '0;
            o_count    <= POS_W'(r_fill);
            o_is_empty <= (r_fill == '0);
        end
    end

    `PLC_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= LW'(CAPACITY), "list length beyond capacity")
    `PLC_ASSERT_NEXT(a_accept_busy, w_accept, r_state == S_EXEC, "accepted command not executing")
    `PLC_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe held over two cycles")
    `PLC_ASSERT_SAME(a_found_ok, o_valid && (o_found_at != '0), o_ok, "match reported without ok")

endmodule

@@ rtl/plc_cell.sv @@
// One element cell of the list row: holds a byte, shifts with its neighbours,
// and registers whether it matches the searched value. Depends on plc_pkg.
module plc_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int LW  = 7
) (
    input  logic                      i_clk,
    input  plc_pkg::t_cell_ctl        i_ctl,
    input  logic [IW-1:0]             i_pos,
    input  logic [LW-1:0]             i_fill,
    input  logic [plc_pkg::VAL_W-1:0] i_left,
    input  logic [plc_pkg::VAL_W-1:0] i_right,
    output logic [plc_pkg::VAL_W-1:0] o_data,
    output logic                      o_match
);
    import plc_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;
    logic             r_match;
    logic             w_at;
    logic             w_above;
    logic             w_live;

    assign w_at    = (i_pos == IW'(IDX));
    assign w_above = (i_pos < IW'(IDX));
    assign w_live  = (i_fill > LW'(IDX));

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_data = i_left;
            end else if (w_at) begin
                n_data = i_ctl.val;
            end
        end else if (i_ctl.del) begin
            if (w_above || w_at) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.exec) begin
            r_match <= (r_data == i_ctl.val) && w_live;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

@@ rtl/plc_find.sv @@
// Two-step first-match search over the cell match flags: a registered
// priority pick inside each group of eight, then a pick across groups.
// Depends on plc_pkg.
module plc_find #(
    parameter int N  = plc_pkg::DEF_CAPACITY,
    parameter int PW = 7
) (
    input  logic          i_clk,
    input  logic [N-1:0]  i_match,
    output logic          o_hit,
    output logic [PW-1:0] o_pos
);
    import plc_pkg::*;

    localparam int NG = (N + GRP - 1) / GRP;
    localparam int GW = $clog2(GRP);

    logic [NG*GRP-1:0] w_pad;
    logic [NG-1:0]     r_ghit;
    logic [NG-1:0]     n_ghit;
    logic [GW-1:0]     r_gidx [NG];
    logic [GW-1:0]     n_gidx [NG];

    assign w_pad = (NG*GRP)'(i_match);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_ghit[g] = |w_pad[g*GRP +: GRP];
            n_gidx[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (w_pad[g*GRP + j]) begin
                    n_gidx[g] = GW'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ghit <= n_ghit;
        for (int g = 0; g < NG; g++) begin
            r_gidx[g] <= n_gidx[g];
        end
    end

    always_comb begin
        o_hit = 1'b0;
        o_pos = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_ghit[g]) begin
                o_hit = 1'b1;
                o_pos = PW'(g * GRP) + PW'(r_gidx[g]) + PW'(1);
            end
        end
    end

endmodule

@@ tb/sv/positional_list_store_core_tb.sv @@
// Self-checking testbench for positional_list_store_core: directed and random list commands
// driven over the start/busy handshake, each strobed result checked against a predictor.
// Depends on plc_pkg and the positional_list_store_core RTL.
`timescale 1ns / 1ps

module positional_list_store_core_tb;
    import plc_pkg::*;

    localparam int DEPTH        = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             drain;
        logic [5:0]       gap;
    } t_list_req;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] item;
        logic [POS_W-1:0] found_at;
        logic [POS_W-1:0] count;
        logic             is_empty;
    } t_list_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] i_cmd = '0;
    logic [POS_W-1:0] i_position = '0;
    logic [VAL_W-1:0] i_value = '0;
    logic             o_valid;
    logic             o_ok;
    logic [VAL_W-1:0] o_item;
    logic [POS_W-1:0] o_found_at;
    logic [POS_W-1:0] o_count;
    logic             o_is_empty;

    // Predicted contents of the list.
    logic [VAL_W-1:0] list_mem [DEPTH];
    int               list_len = 0;

    // Generator-side view of the list, used only to steer the stimulus.
    logic [VAL_W-1:0] shadow [$];

    t_list_req   cmd_backlog [$];
    t_list_reply expected_replies [$];
    t_list_req   cur_req;
    int          gap_left = 0;
    int          accepted_total = 0;
    int          replied_total = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          n_get = 0, n_locate_hit = 0, n_insert = 0, n_delete = 0;
    int          n_refused = 0, n_full_refused = 0, n_full_reached = 0, n_drains = 0;

    positional_list_store_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_ok       (o_ok),
        .o_item     (o_item),
        .o_found_at (o_found_at),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    // Applies one command to the predicted list and returns the reply it should produce.
    function automatic t_list_reply apply_list_cmd(t_list_req rq);
        t_list_reply r;
        int          p;
        int          k;
        r = '0;
        p = rq.pos;
        case (rq.cmd)
            CMD_GET: begin
                if (p >= 1 && p <= list_len) begin
                    r.ok   = 1'b1;
                    r.item = list_mem[p-1];
                    n_get++;
                end else begin
                    n_refused++;
                end
            end
            CMD_LOCATE: begin
                for (k = 0; k < list_len; k++) begin
                    if (!r.ok && list_mem[k] == rq.val) begin
                        r.ok       = 1'b1;
                        r.found_at = 7'(k + 1);
                    end
                end
                if (r.ok)
                    n_locate_hit++;
            end
            CMD_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
                    for (k = list_len; k > p - 1; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = rq.val;
                    list_len++;
                    r.ok = 1'b1;
                    n_insert++;
                    if (list_len == DEPTH)
                        n_full_reached++;
                end else if (list_len == DEPTH) begin
                    n_full_refused++;
                end else begin
                    n_refused++;
                end
            end
            default: begin
                if (p >= 1 && p <= list_len) begin
                    r.item = list_mem[p-1];
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                    r.ok = 1'b1;
                    n_delete++;
                end else begin
                    n_refused++;
                end
            end
        endcase
        r.count    = 7'(list_len);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(int w_ins, int w_del, int w_get);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            return CMD_INSERT;
        else if (r < w_ins + w_del)
            return CMD_DELETE;
        else if (r < w_ins + w_del + w_get)
            return CMD_GET;
        return CMD_LOCATE;
    endfunction

    // Mostly legal positions; the rest sit just past the end, at zero or far out.
    function automatic int pick_pos(logic [CMD_W-1:0] c);
        int hi;
        hi = (c == CMD_INSERT) ? shadow.size() + 1 : shadow.size();
        if ($urandom_range(0, 99) < 85 && hi >= 1)
            return $urandom_range(1, hi);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return hi + 1;
            2:       return 64;
            3:       return 65;
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    // Locate mostly searches for a stored element; a narrow value range gives duplicates.
    function automatic logic [VAL_W-1:0] pick_val(logic [CMD_W-1:0] c);
        int r;
        r = $urandom_range(0, 99);
        if (c == CMD_LOCATE && shadow.size() > 0 && r < 70)
            return shadow[$urandom_range(0, shadow.size() - 1)];
        if (r < 25)
            return VAL_W'($urandom_range(0, 7));
        return VAL_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] c, input int p, input logic [VAL_W-1:0] v,
                             input bit drain, input int gap);
        t_list_req rq;
        int        len;
        len      = shadow.size();
        rq.cmd   = c;
        rq.pos   = p[POS_W-1:0];
        rq.val   = v;
        rq.drain = drain;
        rq.gap   = gap[5:0];
        cmd_backlog.push_back(rq);
        if (drain)
            n_drains++;
        if (c == CMD_INSERT && p >= 1 && p <= len + 1 && len < DEPTH)
            shadow.insert(p - 1, v);
        else if (c == CMD_DELETE && p >= 1 && p <= len)
            shadow.delete(p - 1);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Sender: a transfer happens on an edge where start is high and busy is low.
    always @(posedge i_clk) begin : send_proc
        bit next_start;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                expected_replies.push_back(apply_list_cmd(cur_req));
                accepted_total++;
                gap_left   = cur_req.gap;
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].drain && replied_total < accepted_total)) begin
                    cur_req    = cmd_backlog.pop_front();
                    i_cmd      <= cur_req.cmd;
                    i_position <= cur_req.pos;
                    i_value    <= cur_req.val;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    always @(posedge i_clk) begin : reply_proc
        t_list_reply want;
        if (i_rst_n && o_valid) begin
            replied_total <= replied_total + 1;
            if (expected_replies.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected nothing, actual count %0d",
                         $time, o_count);
            end else begin
                want = expected_replies.pop_front();
                check_field("ok", want.ok, o_ok);
                check_field("item", want.item, o_item);
                check_field("found_at", want.found_at, o_found_at);
                check_field("count", want.count, o_count);
                check_field("is_empty", want.is_empty, o_is_empty);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, accepted_total - replied_total);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stim_proc
        int               kind;
        int               steps;
        int               step_cap;
        int               rand_count;
        bit               burst;
        bit               ending;
        logic [CMD_W-1:0] c;

        // Directed: empty-list refusals, end and middle inserts, duplicates, extremes.
        queue_cmd(CMD_GET,    1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_DELETE, 1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_LOCATE, 0,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 0,   8'h11, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 2,   8'h22, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 1,   8'hFF, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 3,   8'hA5, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 2,   8'hA5, 1'b0, pick_gap());
        queue_cmd(CMD_LOCATE, 0,   8'hA5, 1'b0, pick_gap());
        queue_cmd(CMD_LOCATE, 127, 8'h5A, 1'b0, pick_gap());
        queue_cmd(CMD_GET,    1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_GET,    4,   8'hFF, 1'b0, pick_gap());
        queue_cmd(CMD_GET,    5,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_GET,    0,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 6,   8'h33, 1'b0, pick_gap());
        queue_cmd(CMD_INSERT, 127, 8'h80, 1'b0, pick_gap());
        queue_cmd(CMD_DELETE, 127, 8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_DELETE, 4,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_DELETE, 1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_LOCATE, 0,   8'hFF, 1'b0, pick_gap());
        queue_cmd(CMD_GET,    64,  8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_DELETE, 1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_DELETE, 1,   8'h00, 1'b0, pick_gap());
        queue_cmd(CMD_GET,    65,  8'h00, 1'b0, pick_gap());

        // Random phases: fill to capacity, drain to empty, or wander; the first one fills.
        rand_count = 0;
        kind       = 0;
        while (rand_count < RANDOM_ITEMS) begin
            burst    = ($urandom_range(0, 3) == 0);
            ending   = 1'b0;
            steps    = 0;
            step_cap = (kind == 2) ? $urandom_range(20, 60) : 250;
            while (steps < step_cap && rand_count < RANDOM_ITEMS) begin
                if ($urandom_range(0, 99) < 5) begin
                    c = CMD_W'($urandom_range(0, 3));
                    queue_cmd(c, $urandom_range(0, 127), VAL_W'($urandom_range(0, 255)),
                              rand_count == 0, burst ? 0 : pick_gap());
                end else begin
                    case (kind)
                        0:       c = pick_cmd(65, 10, 15);
                        1:       c = pick_cmd(10, 60, 15);
                        default: c = pick_cmd(30, 25, 20);
                    endcase
                    queue_cmd(c, pick_pos(c), pick_val(c),
                              rand_count == 0 || $urandom_range(0, 99) == 0,
                              burst ? 0 : pick_gap());
                end
                steps++;
                rand_count++;
                // A few more commands once full or empty, so those edges get exercised.
                if (kind != 2 && !ending && shadow.size() == ((kind == 0) ? DEPTH : 0)) begin
                    ending   = 1'b1;
                    step_cap = steps + 4;
                end
            end
            kind = $urandom_range(0, 2);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge i_clk);
        while (replied_total < accepted_total)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Ran %0d commands: %0d inserts, %0d deletes, %0d gets, %0d locate hits.",
                 accepted_total, n_insert, n_delete, n_get, n_locate_hit);
        $display("List filled %0d times, %0d inserts refused when full, %0d out of range, %s",
                 n_full_reached, n_full_refused, n_refused, $sformatf("%0d drains.", n_drains));
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
